FILE: hdl/pip_pkg.sv
// shared types, sizes and codes of the point-in-polygon keep test
// used by pip_cell, pip_edge, the top level and the checker; no dependencies
package pip_pkg;

  // store depth and coordinate width
  localparam int MAX_VERTICES = 256;
  localparam int COORD_W      = 32;

  // derived sizes
  localparam int ADDR_W  = $clog2(MAX_VERTICES);
  localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
  localparam int ENTRY_W = 2 * COORD_W;
  localparam int REL_W   = COORD_W + 1;
  localparam int PROD_W  = 2 * REL_W;

  // action codes of an input word
  localparam logic [1:0] ACT_LOAD_POLY = 2'd0;
  localparam logic [1:0] ACT_LOAD_MARK = 2'd1;
  localparam logic [1:0] ACT_QUERY     = 2'd2;

  // configuration register indexes
  localparam logic [0:0] REG_VERTEX_COUNT = 1'd0;
  localparam logic [0:0] REG_FOREIGN_MODE = 1'd1;

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;

  // vertex token handed from cell to cell
  typedef struct packed {
    logic   vld;
    logic   chk;
    logic   last;
    coord_t x;
    coord_t y;
    coord_t mx;
    coord_t my;
  } pip_tok_t;

  // vertex relative to the query point
  typedef struct packed {
    logic signed [REL_W-1:0] rx;
    logic signed [REL_W-1:0] ry;
    logic                    up;
    logic                    hit;
  } pip_rel_t;

  // edge unit result towards the sequencer
  typedef struct packed {
    logic done;
    logic flip;
  } pip_evt_t;

endpackage

FILE: hdl/pip_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module pip_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/pip_cell.sv
// one cell of the vertex chain: holds a vertex and its offset from the query point
// depends on pip_pkg
module pip_cell import pip_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  coord_t   tx_i,
  input  coord_t   ty_i,
  input  pip_tok_t tok_i,
  output pip_tok_t tok_o,
  output pip_rel_t rel_o
);

  pip_tok_t tok_q;
  pip_rel_t rel_d, rel_q;

  // offsets, side of the ray and stored-point match
  always_comb begin
    rel_d.rx  = $signed({tok_i.x[COORD_W-1], tok_i.x}) - $signed({tx_i[COORD_W-1], tx_i});
    rel_d.ry  = $signed({tok_i.y[COORD_W-1], tok_i.y}) - $signed({ty_i[COORD_W-1], ty_i});
    rel_d.up  = tok_i.y > ty_i;
    rel_d.hit = tok_i.vld & tok_i.chk & (tok_i.mx == tx_i) & (tok_i.my == ty_i);
  end

  // hand the vertex on to the neighbour every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      rel_q <= '0;
    end else begin
      tok_q <= tok_i;
      rel_q <= rel_d;
    end
  end

  assign tok_o = tok_q;
  assign rel_o = rel_q;

endmodule

FILE: hdl/pip_edge.sv
// edge crossing unit: cross products of two neighbouring vertices, then sign test
// depends on pip_pkg
module pip_edge import pip_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  logic     last_i,
  input  pip_rel_t near_i,
  input  pip_rel_t far_i,
  output pip_evt_t evt_o
);

  logic signed [PROD_W-1:0] ad_d, cb_d, ad_q, cb_q;
  logic                     vld_q, last_q, cross_q, upj_q;
  logic [PROD_W:0]          diff;
  logic                     pos, neg;

  // products of the offsets
  always_comb begin
    ad_d = near_i.rx * far_i.ry;
    cb_d = far_i.rx * near_i.ry;
  end

  // control of the product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      last_q <= 1'b0;
    end else begin
      vld_q  <= fire_i;
      last_q <= fire_i & last_i;
    end
  end

  // product stage payload
  always_ff @(posedge clk_i) begin
    ad_q    <= ad_d;
    cb_q    <= cb_d;
    cross_q <= near_i.up ^ far_i.up;
    upj_q   <= far_i.up;
  end

  // the ray crosses when the intersection lies right of the point
  always_comb begin
    diff       = {ad_q[PROD_W-1], ad_q} - {cb_q[PROD_W-1], cb_q};
    neg        = diff[PROD_W];
    pos        = ~neg & (diff != '0);
    evt_o.flip = vld_q & cross_q & ((pos & upj_q) | (neg & ~upj_q));
    evt_o.done = last_q;
  end

endmodule

FILE: hdl/point_in_polygon_keep_test.sv
// top level of the point-in-polygon keep test
// depends on pip_pkg, pip_ram, pip_cell and pip_edge
//
// Input channel (in_valid_i / in_stall_o) takes one word per accepted cycle:
// action 0 writes (px, py) to polygon slot, action 1 to marker slot, action 2
// queries the point, action 3 is dropped. Loads give no result and leave the
// input free. A query gives one keep word on the output channel (out_valid_o /
// out_stall_i): 1 for an exact stored-point match or a point outside, 0 inside.
// A query walks the n = min(vertex_count, 256) vertices once through the
// two-cell vertex chain and the edge unit, one vertex per cycle from the
// single read port of each store. The result is formed when the edge unit
// flags the closing edge (at once when n is 0), and the input stays stalled
// until the keep word has moved into the output register. A finished keep
// word sits in the output register while the receiver stalls; the block
// goes on taking words and runs the next query, holding its answer until
// the output register frees up.
// Configuration (cfg_valid_i / cfg_ready_o) is always ready; write it only
// while no query is in flight. Reset clears control and configuration; the
// stores hold nothing defined until written.
module point_in_polygon_keep_test import pip_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  slot_i,
  input  logic [31:0] px_i,
  input  logic [31:0] py_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        keep_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);

  logic [1:0]        st_q, st_d;
  logic [8:0]        vcount_q;
  logic              foreign_q;
  coord_t            tx_q, ty_q, px_c, py_c;
  logic [CNT_W-1:0]  n_q, n_sat, cnt_q, cnt_d;
  logic              rd_vld_q, rd_chk_q, rd_last_q;
  logic              rd_vld_d, rd_chk_d, rd_last_d;
  logic              hit_q, hit_d, par_q, par_d, res_q, res_d;
  logic              out_vld_q, out_vld_d, out_keep_q, out_keep_d;
  logic              in_acc, is_query, slot_ok, poly_we, mark_we;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [ENTRY_W-1:0] poly_rd, mark_rd, wdata;
  pip_tok_t          tok_in, tok0, tok1;
  pip_rel_t          rel0, rel1;
  pip_evt_t          evt;

  // input handshake and load decode
  assign in_stall_o = (st_q != ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign is_query   = in_acc & (action_i == ACT_QUERY);
  assign slot_ok    = 32'(slot_i) < MAX_VERTICES;
  assign poly_we    = in_acc & (action_i == ACT_LOAD_POLY) & slot_ok;
  assign mark_we    = in_acc & (action_i == ACT_LOAD_MARK) & slot_ok;
  assign px_c       = px_i[COORD_W-1:0];
  assign py_c       = py_i[COORD_W-1:0];
  assign waddr      = ADDR_W'(slot_i);
  assign wdata      = {px_c, py_c};

  // vertex count saturated to the store depth
  always_comb begin
    if (32'(vcount_q) > MAX_VERTICES) begin
      n_sat = CNT_W'(MAX_VERTICES);
    end else begin
      n_sat = CNT_W'(vcount_q);
    end
  end

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q  <= '0;
      foreign_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_VERTEX_COUNT: vcount_q  <= cfg_data_i;
        REG_FOREIGN_MODE: foreign_q <= cfg_data_i[0];
        default:          vcount_q  <= vcount_q;
      endcase
    end
  end

  // polygon and marker stores
  pip_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_VERTICES)) u_poly_ram (
    .clk_i   (clk_i),
    .we_i    (poly_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (poly_rd)
  );

  pip_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_VERTICES)) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (mark_rd)
  );

  // read walk: vertices 0 to n-1, then vertex 0 again to close the polygon
  assign raddr = (cnt_q == n_q) ? '0 : cnt_q[ADDR_W-1:0];

  // sequencer
  always_comb begin
    st_d       = st_q;
    cnt_d      = cnt_q;
    rd_vld_d   = 1'b0;
    rd_chk_d   = 1'b0;
    rd_last_d  = 1'b0;
    hit_d      = hit_q | rel0.hit;
    par_d      = par_q ^ evt.flip;
    res_d      = res_q;
    out_vld_d  = out_vld_q & out_stall_i;
    out_keep_d = out_keep_q;
    case (st_q)
      ST_IDLE: begin
        if (is_query) begin
          cnt_d = '0;
          hit_d = 1'b0;
          par_d = 1'b0;
          if (n_sat == '0) begin
            res_d = 1'b1;
            st_d  = ST_FIN;
          end else begin
            st_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        rd_vld_d  = 1'b1;
        rd_chk_d  = (cnt_q != n_q);
        rd_last_d = (cnt_q == n_q);
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == n_q) begin
          st_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (evt.done) begin
          res_d = hit_d | ~par_d;
          st_d  = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d  = 1'b1;
          out_keep_d = res_q;
          st_d       = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_chk_q  <= 1'b0;
      rd_last_q <= 1'b0;
      hit_q     <= 1'b0;
      par_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      rd_chk_q  <= rd_chk_d;
      rd_last_q <= rd_last_d;
      hit_q     <= hit_d;
      par_q     <= par_d;
      out_vld_q <= out_vld_d;
    end
  end

  // query point, walk length and result payload
  always_ff @(posedge clk_i) begin
    if (is_query) begin
      tx_q <= px_c;
      ty_q <= py_c;
      n_q  <= n_sat;
    end
    res_q      <= res_d;
    out_keep_q <= out_keep_d;
  end

  // token entering the chain; match source follows the mode
  always_comb begin
    tok_in.vld  = rd_vld_q;
    tok_in.chk  = rd_chk_q;
    tok_in.last = rd_last_q;
    tok_in.x    = poly_rd[ENTRY_W-1:COORD_W];
    tok_in.y    = poly_rd[COORD_W-1:0];
    tok_in.mx   = foreign_q ? poly_rd[ENTRY_W-1:COORD_W] : mark_rd[ENTRY_W-1:COORD_W];
    tok_in.my   = foreign_q ? poly_rd[COORD_W-1:0] : mark_rd[COORD_W-1:0];
  end

  // vertex chain: cell 0 holds vertex i, cell 1 the one before it
  pip_cell u_cell0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tx_i   (tx_q),
    .ty_i   (ty_q),
    .tok_i  (tok_in),
    .tok_o  (tok0),
    .rel_o  (rel0)
  );

  pip_cell u_cell1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tx_i   (tx_q),
    .ty_i   (ty_q),
    .tok_i  (tok0),
    .tok_o  (tok1),
    .rel_o  (rel1)
  );

  // edge test on the pair held by the two cells
  pip_edge u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (tok0.vld & tok1.vld),
    .last_i (tok0.last),
    .near_i (rel0),
    .far_i  (rel1),
    .evt_o  (evt)
  );

  assign out_valid_o = out_vld_q;
  assign keep_o      = out_keep_q;

endmodule

FILE: hdl/pip_chk.sv
// port-level checker for the point-in-polygon keep test, bound to the top level
// depends on pip_pkg and point_in_polygon_keep_test
module pip_chk import pip_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  action_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        keep_o
);

  logic in_acc;
  assign in_acc = in_valid_i & ~in_stall_o;

  // a stalled result word stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // a stalled result word keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(keep_o))
    else $error("result word changed while stalled");

  // no result appears in the cycle after a word is taken
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_o))
    else $error("result word appeared too early");

  // a query keeps the input side busy
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (action_i == ACT_QUERY) |=> in_stall_o)
    else $error("input taken during a query");

  // loads never block the input side
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && ((action_i == ACT_LOAD_POLY) || (action_i == ACT_LOAD_MARK)) |=> !in_stall_o)
    else $error("input stalled after a load");

endmodule

bind point_in_polygon_keep_test pip_chk u_pip_chk (.*);
